>>> rtl/fssc_pkg.sv
// ---------------------------------------------------------------------------
// fssc_pkg: shared types and constants of the four-servo slew controller
// Action codes, angle widths and the per-servo state and command bundles.
// ---------------------------------------------------------------------------
package fssc_pkg;

    localparam int NUM_SERVO  = 4;
    localparam int SLOT_W     = 2;
    localparam int ANGLE_W    = 8;
    localparam int ID_W       = 8;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ID_W-1:0]    ID_FIRST       = 8'd6;
    localparam logic [ID_W-1:0]    ID_LAST        = 8'd9;
    localparam logic [ANGLE_W-1:0] HOME_ANGLE     = 8'd90;
    localparam logic [ANGLE_W-1:0] RAMP_STEP_DEG  = 8'd3;
    localparam logic [ANGLE_W-1:0] MIN_RESET      = 8'd0;
    localparam logic [ANGLE_W-1:0] MAX_RESET      = 8'd180;
    localparam logic [ANGLE_W-1:0] BAD_SET_RESULT = 8'd255;

    // action codes; code 7 is a no-op
    localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_NUDGE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_STOP  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_AUTO  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RESET = 3'd5;
    localparam logic [ACT_W-1:0] ACT_POLL  = 3'd6;

    typedef struct packed {
        logic [ANGLE_W-1:0] cur;
        logic [ANGLE_W-1:0] tgt;
        logic               auto_on;
        logic               sweep_down;
        logic               ext;
    } t_lane_state;

    // per-lane decoded command; select already folded in
    typedef struct packed {
        logic tick;
        logic set;
        logic nudge;
        logic stop;
        logic auto_go;
        logic home;
    } t_lane_cmd;

    typedef struct packed {
        logic moved_ext;
        logic stop_ext;
    } t_lane_flags;

endpackage

>>> rtl/fssc_lane.sv
// ---------------------------------------------------------------------------
// fssc_lane: next-state logic of one servo
// Hold ramp, auto sweep, set/nudge clamp, stop, auto entry and home.
// ---------------------------------------------------------------------------
module fssc_lane #(
    parameter logic [fssc_pkg::ANGLE_W-1:0] STEP_DEG = fssc_pkg::RAMP_STEP_DEG,
    parameter logic [fssc_pkg::ANGLE_W-1:0] HOME_DEG = fssc_pkg::HOME_ANGLE
) (
    input  fssc_pkg::t_lane_cmd          i_cmd,
    input  logic [fssc_pkg::ANGLE_W-1:0] i_angle_value,
    input  logic signed [fssc_pkg::ANGLE_W-1:0] i_nudge_delta,
    input  logic [fssc_pkg::ANGLE_W-1:0] i_min,
    input  logic [fssc_pkg::ANGLE_W-1:0] i_max,
    input  fssc_pkg::t_lane_state        i_state,
    output fssc_pkg::t_lane_state        o_state,
    output fssc_pkg::t_lane_flags        o_flags
);
    import fssc_pkg::*;

    localparam int SW = ANGLE_W + 2;

    // min first, then max: min > max yields max
    function automatic logic [ANGLE_W-1:0] clamp_angle(
        input logic signed [SW-1:0] v,
        input logic [ANGLE_W-1:0]   mn,
        input logic [ANGLE_W-1:0]   mx
    );
        logic signed [SW-1:0] t;
        t = v;
        if (t < signed'({2'b00, mn})) t = signed'({2'b00, mn});
        if (t > signed'({2'b00, mx})) t = signed'({2'b00, mx});
        return t[ANGLE_W-1:0];
    endfunction

    logic signed [SW-1:0] cur_s, tgt_s, min_s, max_s, step_s, up_s, dn_s, sw_s;
    logic [ANGLE_W-1:0]   tick_cur, tick_tgt;
    logic                 tick_down;
    logic [ANGLE_W:0]     mid;

    always_comb begin
        cur_s  = signed'({2'b00, i_state.cur});
        tgt_s  = signed'({2'b00, i_state.tgt});
        min_s  = signed'({2'b00, i_min});
        max_s  = signed'({2'b00, i_max});
        step_s = signed'({2'b00, STEP_DEG});
        up_s   = cur_s + step_s;
        dn_s   = cur_s - step_s;
        sw_s   = i_state.sweep_down ? dn_s : up_s;
        mid    = ({1'b0, i_min} + {1'b0, i_max}) >> 1;

        tick_cur  = i_state.cur;
        tick_tgt  = i_state.tgt;
        tick_down = i_state.sweep_down;
        if (i_state.auto_on) begin
            if (sw_s >= max_s) begin
                tick_cur  = i_max;
                tick_down = 1'b1;
            end else if (sw_s <= min_s) begin
                tick_cur  = i_min;
                tick_down = 1'b0;
            end else begin
                tick_cur  = sw_s[ANGLE_W-1:0];
            end
            tick_tgt = tick_cur;
        end else if (cur_s < tgt_s) begin
            tick_cur = (up_s > tgt_s) ? i_state.tgt : up_s[ANGLE_W-1:0];
        end else if (cur_s > tgt_s) begin
            tick_cur = (dn_s < tgt_s) ? i_state.tgt : dn_s[ANGLE_W-1:0];
        end
    end

    always_comb begin
        o_state = i_state;
        o_flags = '0;
        if (i_cmd.home) begin
            o_state.cur        = HOME_DEG;
            o_state.tgt        = HOME_DEG;
            o_state.auto_on    = 1'b0;
            o_state.sweep_down = 1'b0;
            o_state.ext        = 1'b0;
        end else if (i_cmd.tick) begin
            o_state.cur        = tick_cur;
            o_state.tgt        = tick_tgt;
            o_state.sweep_down = tick_down;
            o_flags.moved_ext  = (tick_cur != i_state.cur) && i_state.ext;
        end else if (i_cmd.set) begin
            o_state.tgt     = clamp_angle(signed'({2'b00, i_angle_value}), i_min, i_max);
            o_state.auto_on = 1'b0;
            o_state.ext     = 1'b0;
        end else if (i_cmd.nudge) begin
            if (i_nudge_delta != '0) begin
                o_state.tgt     = clamp_angle(tgt_s + SW'(i_nudge_delta), i_min, i_max);
                o_state.auto_on = 1'b0;
                o_state.ext     = 1'b1;
            end
        end else if (i_cmd.stop) begin
            o_flags.stop_ext = i_state.ext;
            o_state.auto_on  = 1'b0;
            o_state.tgt      = i_state.cur;
            o_state.ext      = 1'b0;
        end else if (i_cmd.auto_go) begin
            o_state.auto_on    = 1'b1;
            o_state.sweep_down = !({1'b0, i_state.cur} <= mid);
            o_state.ext        = 1'b1;
        end
    end

endmodule

>>> rtl/four_servo_slew_sweep_controller_unit.sv
// ---------------------------------------------------------------------------
// four_servo_slew_sweep_controller_unit: slew-limited control of servos 6..9
// Path from input transaction to result: input reg, then result reg.
// Throughput: one transaction per cycle unless i_out_stall holds; all four servo
// lanes update in parallel in one combinational pass between the two registers.
// Reset (i_rst_n low, synchronous): all servos at home, hold mode, limits 0/180,
// report pending cleared, both pipeline registers empty.
// ---------------------------------------------------------------------------
module four_servo_slew_sweep_controller_unit #(
    parameter logic [fssc_pkg::ANGLE_W-1:0] STEP_DEG = fssc_pkg::RAMP_STEP_DEG,
    parameter logic [fssc_pkg::ANGLE_W-1:0] HOME_DEG = fssc_pkg::HOME_ANGLE
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [fssc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [fssc_pkg::ANGLE_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [fssc_pkg::ACT_W-1:0]            i_action,
    input  logic [fssc_pkg::ID_W-1:0]             i_servo_id,
    input  logic [fssc_pkg::ANGLE_W-1:0]          i_angle_value,
    input  logic signed [fssc_pkg::ANGLE_W-1:0]   i_nudge_delta,
    input  logic                                  i_tx_idle,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_status,
    output logic [fssc_pkg::ANGLE_W-1:0]          o_angle_result,
    output logic [fssc_pkg::ANGLE_W-1:0]          o_angle_s6,
    output logic [fssc_pkg::ANGLE_W-1:0]          o_angle_s7,
    output logic [fssc_pkg::ANGLE_W-1:0]          o_angle_s8,
    output logic [fssc_pkg::ANGLE_W-1:0]          o_angle_s9,
    output logic [fssc_pkg::NUM_SERVO-1:0]        o_auto_mask,
    output logic                                  o_all_reached,
    output logic                                  o_report_fire
);
    import fssc_pkg::*;

    // limit registers
    logic [ANGLE_W-1:0] r_min [NUM_SERVO];
    logic [ANGLE_W-1:0] r_max [NUM_SERVO];

    // servo state and the shared report flag
    t_lane_state r_st [NUM_SERVO];
    t_lane_state n_st [NUM_SERVO];
    t_lane_cmd   lane_cmd [NUM_SERVO];
    t_lane_flags lane_flg [NUM_SERVO];
    logic        r_pend, n_pend;

    // input register
    logic                      r_in_vld;
    logic [ACT_W-1:0]          r_action;
    logic [ID_W-1:0]           r_id;
    logic [ANGLE_W-1:0]        r_angle;
    logic signed [ANGLE_W-1:0] r_delta;
    logic                      r_idle;

    // result register
    logic               r_out_vld;
    logic               r_status;
    logic [ANGLE_W-1:0] r_result;
    logic [ANGLE_W-1:0] r_out_ang [NUM_SERVO];
    logic [NUM_SERVO-1:0] r_mask;
    logic               r_reached;
    logic               r_fire;

    // pipeline control: the result register frees up when empty or taken
    logic adv, proc;
    assign adv        = !r_out_vld || !i_out_stall;
    assign proc       = r_in_vld && adv;
    assign o_in_stall = r_in_vld && !adv;

    // id decode
    logic              id_ok;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id_off;
    assign id_ok  = (r_id >= ID_FIRST) && (r_id <= ID_LAST);
    assign id_off = r_id - ID_FIRST;
    assign slot   = id_off[SLOT_W-1:0];

    // lane commands: addressed ops only reach the selected lane of a known id
    always_comb begin
        for (int i = 0; i < NUM_SERVO; i++) begin
            lane_cmd[i].tick    = (r_action == ACT_TICK);
            lane_cmd[i].home    = (r_action == ACT_RESET);
            lane_cmd[i].set     = (r_action == ACT_SET)   && id_ok && (slot == SLOT_W'(i));
            lane_cmd[i].nudge   = (r_action == ACT_NUDGE) && id_ok && (slot == SLOT_W'(i));
            lane_cmd[i].stop    = (r_action == ACT_STOP)  && id_ok && (slot == SLOT_W'(i));
            lane_cmd[i].auto_go = (r_action == ACT_AUTO)  && id_ok && (slot == SLOT_W'(i));
        end
    end

    for (genvar g = 0; g < NUM_SERVO; g++) begin : g_lane
        fssc_lane #(
            .STEP_DEG (STEP_DEG),
            .HOME_DEG (HOME_DEG)
        ) u_lane (
            .i_cmd         (lane_cmd[g]),
            .i_angle_value (r_angle),
            .i_nudge_delta (r_delta),
            .i_min         (r_min[g]),
            .i_max         (r_max[g]),
            .i_state       (r_st[g]),
            .o_state       (n_st[g]),
            .o_flags       (lane_flg[g])
        );
    end

    // report flag, fire, status and the result fields
    logic                 any_moved, any_stop, n_fire, n_status, n_reached;
    logic [ANGLE_W-1:0]   n_result;
    logic [NUM_SERVO-1:0] n_mask;

    always_comb begin
        any_moved = 1'b0;
        any_stop  = 1'b0;
        n_mask    = '0;
        n_reached = 1'b1;
        for (int i = 0; i < NUM_SERVO; i++) begin
            any_moved = any_moved | lane_flg[i].moved_ext;
            any_stop  = any_stop  | lane_flg[i].stop_ext;
            n_mask[i] = n_st[i].auto_on;
            if (n_st[i].cur != n_st[i].tgt) n_reached = 1'b0;
        end

        n_pend = r_pend;
        n_fire = 1'b0;
        if (any_moved || any_stop) n_pend = 1'b1;
        if (r_action == ACT_RESET) n_pend = 1'b0;
        if ((r_action == ACT_POLL) && r_pend && r_idle) begin
            n_fire = 1'b1;
            n_pend = 1'b0;
        end

        n_status = !id_ok && ((r_action == ACT_SET) || (r_action == ACT_NUDGE) ||
                              (r_action == ACT_STOP) || (r_action == ACT_AUTO));

        // set reports its clamped target; others the addressed current angle
        if (r_action == ACT_SET) begin
            n_result = id_ok ? n_st[slot].tgt : BAD_SET_RESULT;
        end else begin
            n_result = id_ok ? n_st[slot].cur : '0;
        end
    end

    // limit registers; to be written only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SERVO; i++) begin
                r_min[i] <= MIN_RESET;
                r_max[i] <= MAX_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx[CFG_IDX_W-1]) r_max[i_cfg_idx[SLOT_W-1:0]] <= i_cfg_data;
            else                        r_min[i_cfg_idx[SLOT_W-1:0]] <= i_cfg_data;
        end
    end

    // servo state commits as the transaction moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SERVO; i++) begin
                r_st[i].cur        <= HOME_DEG;
                r_st[i].tgt        <= HOME_DEG;
                r_st[i].auto_on    <= 1'b0;
                r_st[i].sweep_down <= 1'b0;
                r_st[i].ext        <= 1'b0;
            end
            r_pend <= 1'b0;
        end else if (proc) begin
            for (int i = 0; i < NUM_SERVO; i++) r_st[i] <= n_st[i];
            r_pend <= n_pend;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action <= i_action;
            r_id     <= i_servo_id;
            r_angle  <= i_angle_value;
            r_delta  <= i_nudge_delta;
            r_idle   <= i_tx_idle;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_status  <= n_status;
            r_result  <= n_result;
            for (int i = 0; i < NUM_SERVO; i++) r_out_ang[i] <= n_st[i].cur;
            r_mask    <= n_mask;
            r_reached <= n_reached;
            r_fire    <= n_fire;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_status;
    assign o_angle_result = r_result;
    assign o_angle_s6     = r_out_ang[0];
    assign o_angle_s7     = r_out_ang[1];
    assign o_angle_s8     = r_out_ang[2];
    assign o_angle_s9     = r_out_ang[3];
    assign o_auto_mask    = r_mask;
    assign o_all_reached  = r_reached;
    assign o_report_fire  = r_fire;

    // a stalled transaction in the input register stays there
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> r_in_vld)
        else $error("input transaction dropped under stall");

    // a fired report always clears the pending flag
    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_fire) |=> !r_pend)
        else $error("report pending not cleared after fire");

    // fire only happens with a pending report
    a_fire_needs_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_fire) |-> r_pend)
        else $error("report fired without pending flag");

    // reset action sends every servo home
    a_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_action == ACT_RESET)) |=>
        ((r_st[0].cur == HOME_DEG) && (r_st[1].cur == HOME_DEG) &&
         (r_st[2].cur == HOME_DEG) && (r_st[3].cur == HOME_DEG) && !r_pend))
        else $error("reset action left a servo away from home");

endmodule
